### src/five_bit_text_packer_defines.svh
// Assertion macros used by the checker file of five_bit_text_packer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FIVE_BIT_TEXT_PACKER_DEFINES_SVH
`define FIVE_BIT_TEXT_PACKER_DEFINES_SVH

// Same-cycle implication.
`define FBTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fbtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbtp_pkg
// Types, character codes and the window packing function of the text packer.
// ----------------------------------------------------------------------------
package fbtp_pkg;

  localparam logic [6:0] CH_SPACE     = 7'd32;
  localparam logic [6:0] CH_BACKTICK  = 7'd96;
  localparam logic [6:0] CH_DOT       = 7'd46;
  localparam logic [6:0] CH_BAR       = 7'd124;
  localparam logic [6:0] END_MARK     = 7'd123;
  localparam logic [6:0] PAD_MARK     = 7'd125;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Result queue depth; a line end pushes two words at most.
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] word;
    logic        adv3;
  } pack_t;

  typedef struct packed {
    logic [1:0] cnt;   // number of valid results, 0..2
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [6:0] map_char(input logic [6:0] c);
    logic [6:0] v;
    v = c;
    if (c == CH_SPACE) begin
      v = CH_BACKTICK;
    end else if (c == CH_DOT) begin
      v = CH_BAR;
    end
    return v;
  endfunction

  // Three 5-bit codes when all characters sit in the upper range and no byte
  // looks like a newline; otherwise the negated raw pair of c0 and c1.
  function automatic pack_t pack_window(input logic [6:0] c0, input logic [6:0] c1,
                                        input logic [6:0] c2);
    pack_t       r;
    logic [15:0] w;
    logic [15:0] raw;
    w   = {1'b0, c2[4:0], c1[4:0], c0[4:0]};
    raw = {1'b0, c1, 1'b0, c0};
    if ((c0[6:5] == 2'b11) && (c1[6:5] == 2'b11) && (c2[6:5] == 2'b11) &&
        (w[7:0] != NEWLINE_BYTE) && (w[15:8] != NEWLINE_BYTE)) begin
      r.word = w;
      r.adv3 = 1'b1;
    end else begin
      r.word = (~raw) + 16'd1;
      r.adv3 = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/fbtp_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbtp_pack
// Input register, pending character window and packing logic. Each accepted
// character yields zero, one or two result words pushed to the result queue.
// ----------------------------------------------------------------------------
module fbtp_pack (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [6:0]     ch_i,
  input  wire logic           line_end_i,
  input  wire logic           room_i,
  output fbtp_pkg::push_t     push_o
);

  logic       in_valid_q, in_valid_d;
  logic [6:0] ch_q, ch_d;
  logic       line_end_q, line_end_d;
  logic [6:0] pend0_q, pend0_d;
  logic [6:0] pend1_q, pend1_d;
  logic [1:0] pend_cnt_q, pend_cnt_d;

  logic            load;
  logic            fire;
  logic [1:0]      cnt;
  logic [6:0]      q [6];
  fbtp_pkg::pack_t pk0;
  fbtp_pkg::pack_t pk1;
  logic            last0;

  assign fire    = in_valid_q && room_i;
  assign ready_o = !in_valid_q || room_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    ch_d       = ch_q;
    line_end_d = line_end_q;
    if (load) begin
      in_valid_d = 1'b1;
      ch_d       = fbtp_pkg::map_char(ch_i);
      line_end_d = line_end_i;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // Treat a corrupt count of three as two.
  assign cnt = (pend_cnt_q == 2'd3) ? 2'd2 : pend_cnt_q;

  // Window: pending characters, the new one, the end mark, then pad marks.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      q[i] = fbtp_pkg::PAD_MARK;
    end
    case (cnt)
      2'd0: begin
        q[0] = ch_q;
        q[1] = fbtp_pkg::END_MARK;
      end
      2'd1: begin
        q[0] = pend0_q;
        q[1] = ch_q;
        q[2] = fbtp_pkg::END_MARK;
      end
      default: begin
        q[0] = pend0_q;
        q[1] = pend1_q;
        q[2] = ch_q;
        q[3] = fbtp_pkg::END_MARK;
      end
    endcase
  end

  assign pk0 = fbtp_pkg::pack_window(q[0], q[1], q[2]);
  assign pk1 = pk0.adv3 ? fbtp_pkg::pack_window(q[3], q[4], q[5])
                        : fbtp_pkg::pack_window(q[2], q[3], q[4]);

  // The first word closes the line once it has consumed the end mark.
  assign last0 = ({1'b0, pk0.adv3 ? 2'd3 : 2'd2}) > ({1'b0, cnt} + 3'd1);

  always_comb begin
    push_o.cnt     = 2'd0;
    push_o.r0.word = pk0.word;
    push_o.r0.last = 1'b0;
    push_o.r1.word = pk1.word;
    push_o.r1.last = 1'b1;
    pend0_d        = pend0_q;
    pend1_d        = pend1_q;
    pend_cnt_d     = pend_cnt_q;
    if (fire) begin
      if (line_end_q) begin
        push_o.cnt     = last0 ? 2'd1 : 2'd2;
        push_o.r0.last = last0;
        pend0_d        = '0;
        pend1_d        = '0;
        pend_cnt_d     = 2'd0;
      end else if (cnt == 2'd2) begin
        push_o.cnt = 2'd1;
        if (pk0.adv3) begin
          pend_cnt_d = 2'd0;
        end else begin
          pend0_d    = q[2];
          pend_cnt_d = 2'd1;
        end
      end else if (cnt == 2'd1) begin
        pend1_d    = ch_q;
        pend_cnt_d = 2'd2;
      end else begin
        pend0_d    = ch_q;
        pend_cnt_d = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pend0_q    <= '0;
      pend1_q    <= '0;
      pend_cnt_q <= 2'd0;
    end else begin
      in_valid_q <= in_valid_d;
      pend0_q    <= pend0_d;
      pend1_q    <= pend1_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    line_end_q <= line_end_d;
  end

endmodule
`default_nettype wire

### src/fbtp_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbtp_result_fifo
// Small result queue: takes up to two words a cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module fbtp_result_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fbtp_pkg::push_t push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output fbtp_pkg::result_t    data_o
);

  localparam int unsigned PTR_W = $clog2(fbtp_pkg::RES_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  fbtp_pkg::result_t mem_q [fbtp_pkg::RES_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  // Keep space for a full line-end push.
  assign room_o  = (count_q <= CNT_W'(fbtp_pkg::RES_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

endmodule
`default_nettype wire

### src/five_bit_text_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// five_bit_text_packer
// Packs a stream of 7-bit text characters into 16-bit words, line by line.
// ----------------------------------------------------------------------------
// One character is accepted per cycle while the result queue has room. Space
// becomes '`' and '.' becomes '|'; after the character flagged by tlast the
// line gets a '{' terminator and '}' padding. Three characters of 96 and up
// pack into a positive word of three 5-bit codes unless a byte of it equals
// a newline; otherwise two characters go out as the negated raw pair. A
// mid-line character yields at most one word, a line end one or two, the
// final one flagged by tlast. Words leave through a four-entry result queue,
// one per beat; the input stalls only while that queue has fewer than two
// free entries, so with the output side taking every beat the block sustains
// one character per cycle; words go from the input register to the queue.
module five_bit_text_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [6:0] ch, [7] zero
  input  wire logic        s_axis_tlast_i,   // line_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] word (two's complement)
  output logic             m_axis_tlast_o    // is_last
);

  fbtp_pkg::push_t   push;
  fbtp_pkg::result_t head;
  logic              room;

  fbtp_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .ch_i       (s_axis_tdata_i[6:0]),
    .line_end_i (s_axis_tlast_i),
    .room_i     (room),
    .push_o     (push)
  );

  fbtp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  assign m_axis_tdata_o = head.word;
  assign m_axis_tlast_o = head.last;

endmodule
`default_nettype wire

### src/fbtp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbtp_checker
// Port-level assertions for five_bit_text_packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "five_bit_text_packer_defines.svh"

module fbtp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  logic        out_stall;
  logic [16:0] out_beat;
  logic        code_beat;
  logic        raw_beat;
  logic        no_nl;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_beat  = {m_axis_tlast_o, m_axis_tdata_o};
  assign code_beat = m_axis_tvalid_o && !m_axis_tdata_o[15];
  assign raw_beat  = m_axis_tvalid_o && m_axis_tdata_o[15];
  assign no_nl     = (m_axis_tdata_o[7:0] != fbtp_pkg::NEWLINE_BYTE) &&
                     (m_axis_tdata_o[15:8] != fbtp_pkg::NEWLINE_BYTE);

  // Hold a stalled output beat.
  `FBTP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_beat), "stalled beat moved")

  // A code word never carries a newline byte.
  `FBTP_ASSERT_NOW(a_code_no_nl, code_beat, no_nl, "code word holds a newline byte")

  // A raw word is the negation of a nonzero pair of 7-bit bytes.
  `FBTP_ASSERT_NOW(a_raw_range, raw_beat, m_axis_tdata_o[14:0] >= 15'h0081, "raw word out of range")

  // An empty result queue never stalls the input.
  `FBTP_ASSERT_NOW(a_ready_empty, !m_axis_tvalid_o, s_axis_tready_o, "input stalled while empty")

endmodule

bind five_bit_text_packer fbtp_checker u_fbtp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire
